// ----- src/lmfls_pkg.sv -----
// ============================================================================
// LED matrix frame loader package
// Shared constants, the store control group and the row select table.
// ============================================================================
`default_nettype none

package lmfls_pkg;

  // Default number of 8-row frames held in the frame store.
  localparam int unsigned MaxFramesDef = 8;

  // Byte that marks the first three places of a header group.
  localparam logic [7:0] HeaderMark = 8'h2A;

  // Row drive with every row switched off.
  localparam logic [7:0] RowOff = 8'hFF;

  // Control group from the scan/load logic to the frame store.
  typedef struct packed {
    logic clear;   // forget all stored bytes (new header)
    logic wr_en;   // store one payload byte
    logic rd_en;   // read one row byte for a scan tick
  } store_ctl_t;

  // Active-low one-hot row select: row 0 drives the top bit low.
  function automatic logic [7:0] row_select(input logic [2:0] row);
    logic [7:0] sel;
    unique case (row)
      3'd0:    sel = 8'h7f;
      3'd1:    sel = 8'hbf;
      3'd2:    sel = 8'hdf;
      3'd3:    sel = 8'hef;
      3'd4:    sel = 8'hf7;
      3'd5:    sel = 8'hfb;
      3'd6:    sel = 8'hfd;
      3'd7:    sel = 8'hfe;
      default: sel = RowOff;
    endcase
    return sel;
  endfunction

endpackage

`default_nettype wire

// ----- src/lmfls_frame_store.sv -----
// ============================================================================
// LED matrix frame store
// Single-port-write, registered-read byte memory with a fill count that
// stands in for the all-zero state after reset or a new header.
// ============================================================================
`default_nettype none

module lmfls_frame_store #(
  parameter int unsigned MaxFrames = lmfls_pkg::MaxFramesDef,
  parameter int unsigned AddrW     = $clog2(MaxFrames * 8)
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  lmfls_pkg::store_ctl_t  ctl_i,
  input  wire  [AddrW-1:0]       waddr_i,
  input  wire  [7:0]             wdata_i,
  input  wire  [AddrW-1:0]       raddr_i,
  output logic [7:0]             rdata_o,
  output logic                   rd_hit_o
);
  import lmfls_pkg::*;

  localparam int unsigned Depth = MaxFrames * 8;

  logic [7:0]     mem [Depth];
  logic [AddrW:0] fill_q, fill_d;
  logic [7:0]     rdata_q;
  logic           rd_hit_q;

  // Bytes are always written in order from address 0, so every entry below
  // the fill count holds loaded data and every entry at or above it reads as zero.
  always_comb begin
    fill_d = fill_q;
    if (ctl_i.clear) begin
      fill_d = '0;
    end else if (ctl_i.wr_en) begin
      fill_d = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (ctl_i.rd_en) begin
        rd_hit_q <= ({1'b0, raddr_i} < fill_q);
      end
    end
  end

  // Memory write port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Memory read port, registered; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o  = rdata_q;
  assign rd_hit_o = rd_hit_q;

endmodule

`default_nettype wire

// ----- src/led_matrix_frame_loader_scanner.sv -----
// ============================================================================
// LED matrix frame loader and row scanner
// Loads frames from received bytes and scans them out one row per tick.
// ============================================================================
// The block takes one item per clock cycle while its input is not stalled,
// either a received byte or a scan tick, and returns exactly one result item
// for each, through the registered read of the frame store and then the
// output register. A stall on the output holds the pipeline; the input stall
// rises only when both the read stage and the output register are full and
// the output is stalled. Bytes are gathered in groups of eight; a group
// starting with three 0x2A bytes is a header that sets the byte count and
// repeats per frame and restarts loading. The frame store keeps MaxFrames
// frames of eight rows; a fill count makes it read as zero after reset or a
// header, so no clearing pass is needed and the block is ready as soon as
// reset is released.
`default_nettype none

module led_matrix_frame_loader_scanner #(
  parameter int unsigned MaxFrames = lmfls_pkg::MaxFramesDef
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire        func_i,
  input  wire  [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic [7:0] row_drive_o,
  output logic [7:0] column_data_o,
  output logic       display_valid_o,
  output logic       loading_o,
  output logic       header_accepted_o,
  output logic       load_done_o
);
  import lmfls_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxFrames * 8);
  localparam int unsigned FcW   = $clog2(MaxFrames + 1);

  // --------------------------------------------------------------------------
  // State registers
  // --------------------------------------------------------------------------
  logic              phase_q, phase_d;
  logic [7:0]        group_q [6];
  logic [2:0]        pos_q, pos_d;
  logic [15:0]       len_q, len_d;
  logic [7:0]        rep_q, rep_d;
  logic [12:0]       ld_frame_q, ld_frame_d;
  logic [2:0]        ld_row_q, ld_row_d;
  logic [FcW-1:0]    sh_frame_q, sh_frame_d;
  logic [7:0]        sh_rep_q, sh_rep_d;
  logic [2:0]        sh_row_q, sh_row_d;

  // Read stage and output register.
  logic              s1_valid_q, s1_valid_d;
  logic [7:0]        s1_row_q;
  logic              s1_disp_q, s1_load_q, s1_hdr_q, s1_done_q;
  logic              o_valid_q, o_valid_d;
  logic [7:0]        o_row_q, o_col_q;
  logic              o_disp_q, o_load_q, o_hdr_q, o_done_q;

  logic              accept, s1_adv;
  logic              is_header, shown;
  logic              hdr_pulse, done_pulse;
  logic [7:0]        row_sel;
  logic [12:0]       frames_avail;
  logic [FcW-1:0]    n_frames;
  logic [FcW-1:0]    f_cur;
  logic [7:0]        rp_cur, rp_next;
  logic [12:0]       ld_frame_inc;
  logic [15:0]       waddr_wide;
  logic [FcW+2:0]    raddr_wide;
  store_ctl_t        st_ctl;
  logic [7:0]        st_rdata;
  logic              st_hit;

  // --------------------------------------------------------------------------
  // Handshake: the read stage moves on when the output register is free.
  // --------------------------------------------------------------------------
  assign s1_adv     = s1_valid_q && (!o_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  // Frames available for display: min(count / 8, MaxFrames).
  assign frames_avail = len_q[15:3];
  assign n_frames     = (frames_avail > 13'(MaxFrames)) ? FcW'(MaxFrames)
                                                        : frames_avail[FcW-1:0];

  // A header completes on the eighth byte of a group in header phase.
  assign is_header = (pos_q == 3'd7) && (group_q[0] == HeaderMark) &&
                     (group_q[1] == HeaderMark) && (group_q[2] == HeaderMark);

  // Scan position with stale values from an older header restarted.
  assign f_cur   = (sh_frame_q >= n_frames) ? '0 : sh_frame_q;
  assign rp_cur  = (sh_rep_q >= rep_q) ? '0 : sh_rep_q;
  assign rp_next = rp_cur + 8'd1;
  assign shown   = (n_frames != '0) && (rep_q != 8'd0);
  assign row_sel = row_select(sh_row_q);

  assign ld_frame_inc = ld_frame_q + 13'd1;
  assign waddr_wide   = {ld_frame_q, ld_row_q};
  assign raddr_wide   = {f_cur, sh_row_q};

  // --------------------------------------------------------------------------
  // Item processing: header gathering, payload loading and row scanning.
  // --------------------------------------------------------------------------
  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    len_d      = len_q;
    rep_d      = rep_q;
    ld_frame_d = ld_frame_q;
    ld_row_d   = ld_row_q;
    sh_frame_d = sh_frame_q;
    sh_rep_d   = sh_rep_q;
    sh_row_d   = sh_row_q;
    hdr_pulse  = 1'b0;
    done_pulse = 1'b0;
    st_ctl     = '0;

    if (accept && !func_i) begin
      if (!phase_q) begin
        pos_d = pos_q + 3'd1;
        if (is_header) begin
          len_d        = {group_q[4], group_q[3]};
          rep_d        = group_q[5];
          ld_frame_d   = '0;
          ld_row_d     = '0;
          phase_d      = 1'b1;
          hdr_pulse    = 1'b1;
          st_ctl.clear = 1'b1;
        end
      end else begin
        // Bytes for frames beyond the store are counted but dropped.
        st_ctl.wr_en = (ld_frame_q < 13'(MaxFrames));
        ld_row_d     = ld_row_q + 3'd1;
        if (ld_row_q == 3'd7) begin
          ld_frame_d = ld_frame_inc;
        end
        if (ld_frame_d == len_q[15:3]) begin
          ld_frame_d = '0;
          ld_row_d   = '0;
          phase_d    = 1'b0;
          done_pulse = 1'b1;
        end
      end
    end else if (accept && func_i && shown) begin
      st_ctl.rd_en = 1'b1;
      sh_frame_d   = f_cur;
      sh_rep_d     = rp_cur;
      sh_row_d     = sh_row_q + 3'd1;
      if (sh_row_q == 3'd7) begin
        if (rp_next >= rep_q) begin
          sh_rep_d   = '0;
          sh_frame_d = (f_cur + 1'b1 >= n_frames) ? '0 : f_cur + 1'b1;
        end else begin
          sh_rep_d = rp_next;
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= 1'b0;
      pos_q      <= '0;
      len_q      <= '0;
      rep_q      <= '0;
      ld_frame_q <= '0;
      ld_row_q   <= '0;
      sh_frame_q <= '0;
      sh_rep_q   <= '0;
      sh_row_q   <= '0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      len_q      <= len_d;
      rep_q      <= rep_d;
      ld_frame_q <= ld_frame_d;
      ld_row_q   <= ld_row_d;
      sh_frame_q <= sh_frame_d;
      sh_rep_q   <= sh_rep_d;
      sh_row_q   <= sh_row_d;
    end
  end

  // Header group bytes; only the first six places of a group are kept.
  always_ff @(posedge clk_i) begin
    if (accept && !func_i && !phase_q && (pos_q < 3'd6)) begin
      group_q[pos_q] <= rx_byte_i;
    end
  end

  // --------------------------------------------------------------------------
  // Frame store
  // --------------------------------------------------------------------------
  lmfls_frame_store #(
    .MaxFrames (MaxFrames),
    .AddrW     (AddrW)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (st_ctl),
    .waddr_i  (waddr_wide[AddrW-1:0]),
    .wdata_i  (rx_byte_i),
    .raddr_i  (raddr_wide[AddrW-1:0]),
    .rdata_o  (st_rdata),
    .rd_hit_o (st_hit)
  );

  // --------------------------------------------------------------------------
  // Read stage: side fields wait here for the store read data.
  // --------------------------------------------------------------------------
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_disp_q <= func_i && shown;
      s1_row_q  <= (func_i && shown) ? row_sel : RowOff;
      s1_load_q <= phase_d;
      s1_hdr_q  <= hdr_pulse;
      s1_done_q <= done_pulse;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_comb begin
    o_valid_d = o_valid_q;
    if (s1_adv) begin
      o_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      o_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else begin
      o_valid_q <= o_valid_d;
    end
  end

  // Entries past the fill count read as zero.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      o_row_q  <= s1_row_q;
      o_col_q  <= (s1_disp_q && st_hit) ? st_rdata : 8'd0;
      o_disp_q <= s1_disp_q;
      o_load_q <= s1_load_q;
      o_hdr_q  <= s1_hdr_q;
      o_done_q <= s1_done_q;
    end
  end

  assign out_valid_o       = o_valid_q;
  assign row_drive_o       = o_row_q;
  assign column_data_o     = o_col_q;
  assign display_valid_o   = o_disp_q;
  assign loading_o         = o_load_q;
  assign header_accepted_o = o_hdr_q;
  assign load_done_o       = o_done_q;

endmodule

`default_nettype wire

// ----- src/lmfls_checker.sv -----
// ============================================================================
// LED matrix frame loader checker
// Port-level assertions on result items, bound to the top level.
// ============================================================================
`default_nettype none

module lmfls_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       out_valid_o,
  input wire       out_stall_i,
  input wire [7:0] row_drive_o,
  input wire [7:0] column_data_o,
  input wire       display_valid_o,
  input wire       loading_o,
  input wire       header_accepted_o,
  input wire       load_done_o
);
  import lmfls_pkg::*;

  // A shown row selects exactly one row, driven low.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && display_valid_o) |-> $onehot(~row_drive_o))
    else $error("shown row does not select exactly one row");

  // An item that shows no row leaves all rows off and the columns blank.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !display_valid_o) |->
      (row_drive_o == RowOff) && (column_data_o == 8'd0))
    else $error("blank item drives rows or columns");

  // A completed header always enters loading; a completed payload leaves it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && header_accepted_o) |-> (loading_o && !load_done_o))
    else $error("header accepted without loading");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && load_done_o) |-> (!loading_o && !display_valid_o))
    else $error("load done while still loading or on a tick");

  // A stalled result item stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(row_drive_o) && $stable(column_data_o)))
    else $error("stalled result item changed");

endmodule

bind led_matrix_frame_loader_scanner lmfls_checker u_lmfls_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .row_drive_o       (row_drive_o),
  .column_data_o     (column_data_o),
  .display_valid_o   (display_valid_o),
  .loading_o         (loading_o),
  .header_accepted_o (header_accepted_o),
  .load_done_o       (load_done_o)
);

`default_nettype wire
